[rtl/core/wvi_pkg.sv]
package wvi_pkg;

  // control state of the interleaver, one bit per stream where indexed
  typedef struct packed {
    logic       cur_stream;
    logic [1:0] phase_known;
    logic [1:0] phase_positive;
    logic       in_second_half;
    logic [1:0] held_valid;
    logic [1:0] held_is_last;
    logic       done;
  } ctrl_state_t;

  // result flags, packed into m_tuser from bit 0 up
  typedef struct packed {
    logic wrong_source;
    logic finished;
    logic next_source;
    logic has_sample;
  } result_flags_t;

  localparam int unsigned FlagBits = $bits(result_flags_t);

endpackage

[rtl/core/wvi_step.sv]
module wvi_step #(
  parameter int SAMPLE_BITS = 24
) (
  input  wvi_pkg::ctrl_state_t          state,
  input  logic signed [SAMPLE_BITS-1:0] held0,
  input  logic signed [SAMPLE_BITS-1:0] held1,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          source,
  input  logic                          last_of_stream,
  output wvi_pkg::ctrl_state_t          state_next,
  output logic [1:0]                    hold_we,
  output wvi_pkg::result_flags_t        flags,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);
  import wvi_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic                          n;
  logic                          m;
  logic                          wrong;
  logic                          is_zero;
  logic                          is_pos;
  logic                          is_neg;
  logic                          phk;
  logic                          php;
  logic [1:0]                    pk;
  logic [1:0]                    pp;
  logic                          r_pos;
  logic                          r_neg;
  logic                          ends;
  logic                          invert;
  logic                          neg_en;
  logic signed [SAMPLE_BITS-1:0] held_m;
  logic signed [SAMPLE_BITS-1:0] sel;

  always_comb begin
    n       = state.cur_stream;
    m       = ~n;
    wrong   = (source != n);
    is_zero = (in_sample == '0);
    is_neg  = in_sample[SAMPLE_BITS-1];
    is_pos  = ~is_neg & ~is_zero;

    // phase learned from the first nonzero sample of the stream
    phk = state.phase_known[n] | ~is_zero;
    php = state.phase_known[n] ? state.phase_positive[n] : is_pos;
    pk  = state.phase_known;
    pp  = state.phase_positive;
    pk[n] = phk;
    pp[n] = php;

    r_pos = phk & ((is_pos & php) | (is_neg & ~php));
    r_neg = phk & ((is_neg & php) | (is_pos & ~php));
    ends  = state.in_second_half & r_pos;

    invert = (pk == 2'b11) & (pp[0] != pp[1]);
    held_m = m ? held1 : held0;
    sel    = ends ? held_m : in_sample;
    neg_en = invert & (ends ? m : n);
    if (neg_en) begin
      out_sample = (sel == SMin) ? SMax : -sel;
    end else begin
      out_sample = sel;
    end

    state_next = state;
    hold_we    = 2'b00;
    flags      = '0;

    if (state.done) begin
      flags.finished = 1'b1;
    end else if (wrong) begin
      flags.wrong_source = 1'b1;
    end else begin
      state_next.phase_known    = pk;
      state_next.phase_positive = pp;
      if (!ends) begin
        state_next.in_second_half = state.in_second_half | r_neg;
        state_next.done           = last_of_stream;
        flags.has_sample          = 1'b1;
      end else begin
        // cycle boundary: park this sample, hand the turn over
        hold_we[n]                  = 1'b1;
        state_next.held_valid[n]    = 1'b1;
        state_next.held_is_last[n]  = last_of_stream;
        state_next.cur_stream       = m;
        state_next.in_second_half   = 1'b0;
        if (state.held_valid[m]) begin
          state_next.held_valid[m] = 1'b0;
          flags.has_sample         = 1'b1;
          if (state.held_is_last[m]) begin
            state_next.held_is_last[m] = 1'b0;
            state_next.done            = 1'b1;
          end
        end
      end
    end

    if (!flags.has_sample) begin
      out_sample = '0;
    end
    flags.next_source = state_next.cur_stream;
    flags.finished    = state_next.done;
  end

endmodule

[rtl/core/waveset_interleaver.sv]
// waveset interleaver: merges two audio streams by alternating whole
// zero-crossing cycles, starting with stream 0
// input channel s_*: one sample per transfer, s_tuser names its stream and
// s_tlast marks the final sample of that stream
// output channel m_*: exactly one result per input transfer; m_tuser carries
// has_sample, the stream wanted next, finished and wrong_source
// a sample from the stream not asked for is dropped and flagged; after
// finishing every input gets an empty result with finished set
// the result is registered and valid in the cycle after its input transfer
// throughput: one sample per cycle unless stalled; the step logic is one pass
// of sign compares and a saturating negate between state and result register
// stall: s_tready follows the result register, so the block takes a new
// sample in the same cycle the pending result is taken, and holds off
// only while a result sits untaken
// reset: stream 0 requested, phases unknown, nothing held, output empty
module waveset_interleaver #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // in_sample, zero padded to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
  // source
  input  logic                                     s_tuser,
  // last_of_stream
  input  logic                                     s_tlast,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // out_sample, zero padded to whole bytes
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,
  // has_sample, next_source, finished, wrong_source
  output logic [$bits(wvi_pkg::result_flags_t)-1:0] m_tuser
);
  import wvi_pkg::*;

  localparam int DataBits = ((SAMPLE_BITS + 7) / 8) * 8;

  ctrl_state_t                   state;
  ctrl_state_t                   state_next;
  logic signed [SAMPLE_BITS-1:0] held0;
  logic signed [SAMPLE_BITS-1:0] held1;
  logic [1:0]                    hold_we;
  result_flags_t                 flags;
  logic signed [SAMPLE_BITS-1:0] step_sample;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  result_flags_t                 out_flags;
  logic                          s_xfer;

  // result register frees up in the same cycle its transfer happens
  assign s_tready = ~m_tvalid | m_tready;
  assign s_xfer   = s_tvalid & s_tready;

  wvi_step #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_step (
    .state         (state),
    .held0         (held0),
    .held1         (held1),
    .in_sample     (s_tdata[SAMPLE_BITS-1:0]),
    .source        (s_tuser),
    .last_of_stream(s_tlast),
    .state_next    (state_next),
    .hold_we       (hold_we),
    .flags         (flags),
    .out_sample    (step_sample)
  );

  // control state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_xfer) begin
        state <= state_next;
      end
      if (s_xfer) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // held samples: only read while their valid bit is set, so no reset
  always_ff @(posedge clk) begin
    if (s_xfer && hold_we[0]) begin
      held0 <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (s_xfer && hold_we[1]) begin
      held1 <= s_tdata[SAMPLE_BITS-1:0];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      out_sample <= step_sample;
      out_flags  <= flags;
    end
  end

  assign m_tdata = DataBits'($unsigned(out_sample));
  assign m_tuser = out_flags;

endmodule

[rtl/core/wvi_checker.sv]
module wvi_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     s_tvalid,
  input logic                                     s_tready,
  input logic                                     m_tvalid,
  input logic                                     m_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,
  input logic [$bits(wvi_pkg::result_flags_t)-1:0] m_tuser
);
  import wvi_pkg::*;

  result_flags_t f;
  assign f = m_tuser;

  // output comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // an input transfer always produces a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("input transfer without result");

  // an empty result carries zero data
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !f.has_sample |-> m_tdata == '0)
    else $error("data on an empty result");

  // a dropped input carries neither a sample nor the finished flag
  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(f.wrong_source && (f.has_sample || f.finished)))
    else $error("wrong_source with sample or finished");

endmodule

bind waveset_interleaver wvi_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_wvi_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
